[src/deq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package deq_pkg;

	localparam int DEPTH    = 1024;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int WORD_W   = 32;
	localparam int MODE_W   = 3;
	localparam int STATUS_W = 2;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic [MODE_W-1:0]        mode_t;
	typedef logic [STATUS_W-1:0]      status_t;

	localparam mode_t MODE_STATUS     = 3'd0;
	localparam mode_t MODE_PUSH_FRONT = 3'd1;
	localparam mode_t MODE_PUSH_BACK  = 3'd2;
	localparam mode_t MODE_POP_FRONT  = 3'd3;
	localparam mode_t MODE_POP_BACK   = 3'd4;

	localparam status_t ST_OK         = 2'd0;
	localparam status_t ST_POP_EMPTY  = 2'd1;
	localparam status_t ST_PUSH_FULL  = 2'd2;

	function automatic idx_t ring_inc(input idx_t h);
		return (h == idx_t'(DEPTH - 1)) ? '0 : idx_t'(h + idx_t'(1));
	endfunction

	function automatic idx_t ring_dec(input idx_t h);
		return (h == '0) ? idx_t'(DEPTH - 1) : idx_t'(h - idx_t'(1));
	endfunction

	// offset below DEPTH: one conditional subtract wraps the sum
	function automatic idx_t ring_add(input idx_t h, input idx_t off);
		logic [IDX_W:0] s;
		s = {1'b0, h} + {1'b0, off};
		if (s >= (IDX_W+1)'(DEPTH)) begin
			s = s - (IDX_W+1)'(DEPTH);
		end
		return s[IDX_W-1:0];
	endfunction

endpackage
`default_nettype wire

[src/deq_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface deq_req_if;
	logic              valid;
	logic              ready;
	deq_pkg::mode_t    mode;
	deq_pkg::word_t    data_value;

	modport source (output valid, output mode, output data_value, input ready);
	modport sink   (input valid, input mode, input data_value, output ready);
endinterface
`default_nettype wire

[src/deq_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface deq_rsp_if;
	logic              valid;
	logic              ready;
	deq_pkg::word_t    popped_value;
	deq_pkg::status_t  status;
	deq_pkg::cnt_t     count;
	logic              is_empty;
	deq_pkg::word_t    front_value;
	deq_pkg::word_t    back_value;

	modport source (output valid, output popped_value, output status, output count,
		output is_empty, output front_value, output back_value, input ready);
	modport sink   (input valid, input popped_value, input status, input count,
		input is_empty, input front_value, input back_value, output ready);
endinterface
`default_nettype wire

[src/deq_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

[src/double_ended_queue_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | handshake   | word
// req     | in  | valid/ready | mode, data_value
// rsp     | out | valid/ready | popped_value, status, count, is_empty, front_value, back_value
//
// Status, unknown-mode, push and failed ops load the result straight from the accept;
// a successful pop passes through ST_READ for the registered RAM read of the new end word.
// Front and back words are also held in registers; the RAM holds every entry.
// arst_n clears head, count, state and the output valid; no clearing pass.
// A result waiting on rsp stalls only the next item, not the one in flight.
module double_ended_queue_top (
	input wire logic  clk,
	input wire logic  arst_n,
	deq_req_if.sink   req,
	deq_rsp_if.source rsp
);
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_READ = 1'b1;

	logic state_q;
	deq_pkg::idx_t head_q, head_n;
	deq_pkg::cnt_t count_q, count_n;
	deq_pkg::word_t front_q, front_n, back_q, back_n;

	logic pend_front_q;
	deq_pkg::word_t pend_popped_q;

	logic rsp_valid_q;
	deq_pkg::word_t rsp_popped_q, rsp_front_q, rsp_back_q;
	deq_pkg::status_t rsp_status_q;
	deq_pkg::cnt_t rsp_count_q;

	logic acc, go_read, load_now;
	logic we, re;
	deq_pkg::idx_t waddr, raddr;
	logic [deq_pkg::WORD_W-1:0] rdata;
	deq_pkg::word_t popped_n, rd_front, rd_back;
	deq_pkg::status_t status_n;
	logic pend_front_n;

	deq_ram #(.WIDTH(deq_pkg::WORD_W), .DEPTH(deq_pkg::DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (req.data_value),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign req.ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp.ready);
	assign acc       = req.valid && req.ready;

	always_comb begin
		head_n       = head_q;
		count_n      = count_q;
		front_n      = front_q;
		back_n       = back_q;
		popped_n     = '0;
		status_n     = deq_pkg::ST_OK;
		we           = 1'b0;
		waddr        = head_q;
		re           = 1'b0;
		raddr        = head_q;
		go_read      = 1'b0;
		pend_front_n = 1'b0;
		case (req.mode)
			deq_pkg::MODE_PUSH_FRONT, deq_pkg::MODE_PUSH_BACK: begin
				if (count_q == deq_pkg::cnt_t'(deq_pkg::DEPTH)) begin
					status_n = deq_pkg::ST_PUSH_FULL;
				end else begin
					we      = acc;
					count_n = count_q + deq_pkg::cnt_t'(1);
					if (req.mode == deq_pkg::MODE_PUSH_FRONT) begin
						head_n  = deq_pkg::ring_dec(head_q);
						waddr   = head_n;
						front_n = req.data_value;
						if (count_q == '0) begin
							back_n = req.data_value;
						end
					end else begin
						waddr  = deq_pkg::ring_add(head_q, count_q[deq_pkg::IDX_W-1:0]);
						back_n = req.data_value;
						if (count_q == '0) begin
							front_n = req.data_value;
						end
					end
				end
			end
			deq_pkg::MODE_POP_FRONT, deq_pkg::MODE_POP_BACK: begin
				if (count_q == '0) begin
					status_n = deq_pkg::ST_POP_EMPTY;
				end else begin
					go_read = 1'b1;
					re      = acc;
					count_n = count_q - deq_pkg::cnt_t'(1);
					if (req.mode == deq_pkg::MODE_POP_FRONT) begin
						pend_front_n = 1'b1;
						popped_n     = front_q;
						head_n       = deq_pkg::ring_inc(head_q);
						raddr        = head_n;
					end else begin
						popped_n = back_q;
						raddr    = deq_pkg::ring_add(head_q,
							deq_pkg::idx_t'(count_q - deq_pkg::cnt_t'(2)));
					end
					if (count_n == '0) begin
						head_n = '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign load_now = acc && !go_read;
	assign rd_front = pend_front_q ? deq_pkg::word_t'(rdata) : front_q;
	assign rd_back  = pend_front_q ? back_q : deq_pkg::word_t'(rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				head_q  <= head_n;
				count_q <= count_n;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc && go_read) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (load_now || state_q == ST_READ) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			front_q       <= front_n;
			back_q        <= back_n;
			pend_front_q  <= pend_front_n;
			pend_popped_q <= popped_n;
		end else if (state_q == ST_READ) begin
			front_q <= rd_front;
			back_q  <= rd_back;
		end
		if (load_now) begin
			rsp_popped_q <= popped_n;
			rsp_status_q <= status_n;
			rsp_count_q  <= count_n;
			rsp_front_q  <= (count_n != '0) ? front_n : '0;
			rsp_back_q   <= (count_n != '0) ? back_n : '0;
		end else if (state_q == ST_READ) begin
			rsp_popped_q <= pend_popped_q;
			rsp_status_q <= deq_pkg::ST_OK;
			rsp_count_q  <= count_q;
			rsp_front_q  <= (count_q != '0) ? rd_front : '0;
			rsp_back_q   <= (count_q != '0) ? rd_back : '0;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.popped_value = rsp_popped_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.count        = rsp_count_q;
	assign rsp.is_empty     = (rsp_count_q == '0);
	assign rsp.front_value  = rsp_front_q;
	assign rsp.back_value   = rsp_back_q;
endmodule
`default_nettype wire

[tb/sv/double_ended_queue_top_tb.sv]
`timescale 1ns / 1ps
module double_ended_queue_top_tb;
	import deq_pkg::*;

	localparam int     HOLD_CYCLES = 300;
	localparam longint TIMEOUT_NS  = 64'd5_000_000;

	typedef struct packed {
		mode_t mode;
		word_t data;
	} deq_op_t;

	typedef struct packed {
		word_t   popped;
		status_t status;
		cnt_t    count;
		logic    is_empty;
		word_t   front;
		word_t   back;
	} deq_result_t;

	logic clk = 1'b0;
	logic arst_n;

	deq_req_if req_ch ();
	deq_rsp_if rsp_ch ();

	double_ended_queue_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	deq_op_t     op_backlog[$];
	deq_result_t awaited_results[$];

	word_t deque_store[DEPTH];
	int    deque_head;
	int    deque_fill;

	int send_idle;
	int recv_stall;
	int hold_asked;
	int hold_served;
	int hold_left;
	logic req_taken;

	int fail_cnt;
	int ops_accepted;
	int results_checked;
	int full_refusals;
	int empty_pops;
	int peak_fill;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic deq_result_t apply_deque_op(mode_t m, word_t w);
		deq_result_t r;
		r = '0;
		r.status = ST_OK;
		case (m)
			MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
				if (deque_fill >= DEPTH) begin
					r.status = ST_PUSH_FULL;
				end else if (m == MODE_PUSH_FRONT) begin
					deque_head = (deque_head + DEPTH - 1) % DEPTH;
					deque_store[deque_head] = w;
					deque_fill++;
				end else begin
					deque_store[(deque_head + deque_fill) % DEPTH] = w;
					deque_fill++;
				end
			end
			MODE_POP_FRONT, MODE_POP_BACK: begin
				if (deque_fill == 0) begin
					r.status = ST_POP_EMPTY;
				end else if (m == MODE_POP_FRONT) begin
					r.popped = deque_store[deque_head];
					deque_head = (deque_head + 1) % DEPTH;
					deque_fill--;
				end else begin
					r.popped = deque_store[(deque_head + deque_fill - 1) % DEPTH];
					deque_fill--;
				end
				if (deque_fill == 0) begin
					deque_head = 0;
				end
			end
			default: begin
			end
		endcase
		r.count = cnt_t'(deque_fill);
		r.is_empty = (deque_fill == 0);
		if (deque_fill > 0) begin
			r.front = deque_store[deque_head];
			r.back = deque_store[(deque_head + deque_fill - 1) % DEPTH];
		end
		return r;
	endfunction

	task automatic match_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_cnt++;
		end
	endtask

	task automatic add_op(mode_t m, word_t w);
		deq_op_t op;
		op.mode = m;
		op.data = w;
		op_backlog = {op_backlog, op};
	endtask

	function automatic word_t rand_word();
		int pick;
		pick = $urandom_range(19);
		case (pick)
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic mode_t rand_push();
		return $urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
	endfunction

	function automatic mode_t rand_pop();
		return $urandom_range(1) ? MODE_POP_FRONT : MODE_POP_BACK;
	endfunction

	task automatic add_mixed(int n);
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 10) begin
				add_op(MODE_STATUS, rand_word());
			end else if (pick < 55) begin
				add_op(rand_push(), rand_word());
			end else if (pick < 95) begin
				add_op(rand_pop(), rand_word());
			end else begin
				add_op(mode_t'($urandom_range(int'(MODE_POP_BACK) + 1, 7)), rand_word());
			end
		end
	endtask

	task automatic drain_backlog();
		while (op_backlog.size() != 0) begin
			@(negedge clk);
		end
	endtask

	always @(negedge clk) begin
		deq_op_t nxt;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_taken) begin
			if (op_backlog.size() != 0 && $urandom_range(99) >= send_idle) begin
				nxt = op_backlog[0];
				op_backlog.delete(0);
				req_ch.valid <= 1'b1;
				req_ch.mode <= nxt.mode;
				req_ch.data_value <= nxt.data;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_ch.ready <= 1'b0;
		end else if (hold_asked != hold_served) begin
			hold_served <= hold_served + 1;
			hold_left <= HOLD_CYCLES;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	always @(posedge clk) begin
		deq_result_t want;
		req_taken <= arst_n && req_ch.valid && req_ch.ready;
		if (arst_n && req_ch.valid && req_ch.ready) begin
			want = apply_deque_op(req_ch.mode, req_ch.data_value);
			awaited_results = {awaited_results, want};
			ops_accepted++;
			if (want.status == ST_PUSH_FULL) begin
				full_refusals++;
			end
			if (want.status == ST_POP_EMPTY) begin
				empty_pops++;
			end
			if (deque_fill > peak_fill) begin
				peak_fill = deque_fill;
			end
		end
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (awaited_results.size() == 0) begin
				$error("result with no operation outstanding");
				fail_cnt++;
			end else begin
				want = awaited_results[0];
				awaited_results.delete(0);
				match_field("popped_value", want.popped, rsp_ch.popped_value);
				match_field("status", 32'(want.status), 32'(rsp_ch.status));
				match_field("count", 32'(want.count), 32'(rsp_ch.count));
				match_field("is_empty", 32'(want.is_empty), 32'(rsp_ch.is_empty));
				match_field("front_value", want.front, rsp_ch.front_value);
				match_field("back_value", want.back, rsp_ch.back_value);
				results_checked++;
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.mode = MODE_STATUS;
		req_ch.data_value = '0;
		rsp_ch.ready = 1'b0;
		req_taken = 1'b0;
		deque_head = 0;
		deque_fill = 0;
		send_idle = 0;
		recv_stall = 0;
		hold_asked = 0;
		hold_served = 0;
		hold_left = 0;
		fail_cnt = 0;
		ops_accepted = 0;
		results_checked = 0;
		full_refusals = 0;
		empty_pops = 0;
		peak_fill = 0;
		for (int i = 0; i < DEPTH; i++) begin
			deque_store[i] = '0;
		end
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		add_op(MODE_STATUS, '0);
		add_op(MODE_POP_FRONT, 32'h0000_1234);
		add_op(MODE_POP_BACK, 32'hFFFF_FFFF);
		add_op(MODE_PUSH_FRONT, 32'h7FFF_FFFF);
		add_op(MODE_PUSH_BACK, 32'h8000_0000);
		add_op(MODE_PUSH_FRONT, 32'hFFFF_FFFF);
		add_op(MODE_PUSH_BACK, 32'h0000_0000);
		add_op(MODE_PUSH_FRONT, 32'h5555_5555);
		add_op(MODE_PUSH_BACK, 32'hAAAA_AAAA);
		for (int m = int'(MODE_POP_BACK) + 1; m < 8; m++) begin
			add_op(mode_t'(m), 32'hAAAA_AAAA);
		end
		repeat (3) add_op(MODE_POP_FRONT, 32'h5555_5555);
		repeat (3) add_op(MODE_POP_BACK, 32'h5555_5555);
		add_op(MODE_POP_BACK, '0);
		add_op(MODE_POP_FRONT, '0);
		add_op(MODE_PUSH_BACK, 32'h0F0F_F0F0);
		add_op(MODE_POP_FRONT, '0);
		add_mixed(120);
		drain_backlog();

		send_idle = 59;
		add_mixed(120);
		drain_backlog();

		send_idle = 0;
		recv_stall = 59;
		add_mixed(120);
		drain_backlog();

		send_idle = 37;
		recv_stall = 37;
		add_mixed(120);
		drain_backlog();

		send_idle = 0;
		recv_stall = 0;
		hold_asked++;
		add_mixed(100);
		drain_backlog();

		while (req_ch.valid || awaited_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (20) @(negedge clk);

		$display("%0d operations checked against %0d results, deque filled up to %0d of %0d",
			ops_accepted, results_checked, peak_fill, DEPTH);
		$display("%0d pushes refused on a full deque, %0d pops on an empty one",
			full_refusals, empty_pops);
		if (fail_cnt == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
